// ----- rtl/hrlc_pkg.sv -----
// ----------------------------------------------------------------------------
// hrlc_pkg: shared types and constants for the request-line checker
// Byte classes, queue entry layout, verdict codes and the limit reset value.
// ----------------------------------------------------------------------------
`default_nettype none

package hrlc_pkg;

	// Verdict codes given on the result channel.
	localparam logic [1:0] VERDICT_OK                 = 2'd0;
	localparam logic [1:0] VERDICT_BAD_REQUEST        = 2'd1;
	localparam logic [1:0] VERDICT_METHOD_NOT_ALLOWED = 2'd2;
	localparam logic [1:0] VERDICT_TOO_LARGE          = 2'd3;

	// Header byte limit after reset.
	localparam logic [15:0] LIMIT_RESET = 16'd16384;

	// Byte values the checker cares about.
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_G     = 8'h47;
	localparam logic [7:0] CH_E     = 8'h45;
	localparam logic [7:0] CH_T     = 8'h54;
	localparam logic [7:0] CH_H     = 8'h48;
	localparam logic [7:0] CH_P     = 8'h50;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_ONE   = 8'h31;

	// Class of one received byte, decided by the front end.
	typedef enum logic [3:0] {
		CLS_OTHER = 4'd0,
		CLS_CR    = 4'd1,
		CLS_LF    = 4'd2,
		CLS_SPACE = 4'd3,
		CLS_SLASH = 4'd4,
		CLS_G     = 4'd5,
		CLS_E     = 4'd6,
		CLS_T     = 4'd7,
		CLS_H     = 4'd8,
		CLS_P     = 4'd9,
		CLS_DOT   = 4'd10,
		CLS_ZERO  = 4'd11,
		CLS_ONE   = 4'd12
	} cls_t;

	// One classified byte as it waits in the queue.
	typedef struct packed {
		logic start;
		cls_t cls;
	} qitem_t;

endpackage

`default_nettype wire

// ----- rtl/http_request_line_checker.sv -----
// ----------------------------------------------------------------------------
// http_request_line_checker: HTTP request-line checker, top level
// One byte per cycle while in_ready is high; at most one verdict per request.
// ----------------------------------------------------------------------------
// The block accepts one byte per clock cycle without pause as long as
// out_ready keeps up. While a verdict waits in the output register with
// out_ready low, the queue takes at most two more bytes and then in_ready
// drops. A byte is classified and written into a two-entry queue at the edge
// that accepts it. The back end's state update takes it from the queue when
// q_ready is high, and that edge also loads the verdict register, so a
// verdict passes through a queue slot and the verdict register before it
// shows on out_valid. Assert starts_request with the first byte of each
// request. At most one verdict follows per request, and later bytes are
// dropped until the next start. The user must write the header byte limit
// through cfg_we and cfg_wdata only while idle; the block does not check this.
// ----------------------------------------------------------------------------
`default_nettype none

module http_request_line_checker import hrlc_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [15:0] cfg_wdata,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  data_byte,
	input  wire logic        starts_request,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       verdict
);

	logic   q_valid;
	logic   q_ready;
	qitem_t q_item;

	// Front end: classification and queue.
	hrlc_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.data_byte      (data_byte),
		.starts_request (starts_request),
		.q_valid        (q_valid),
		.q_ready        (q_ready),
		.q_item         (q_item)
	);

	// Back end: request state and verdict.
	hrlc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.q_valid   (q_valid),
		.q_ready   (q_ready),
		.q_item    (q_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.verdict   (verdict)
	);

endmodule

`default_nettype wire

// ----- rtl/hrlc_front.sv -----
// ----------------------------------------------------------------------------
// hrlc_front: byte classifier and two-entry queue
// Accepts request bytes, reduces each to a class code and queues it for the
// back end, so that either side can stall without stopping the other.
// ----------------------------------------------------------------------------
`default_nettype none

module hrlc_front import hrlc_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] data_byte,
	input  wire logic       starts_request,
	output logic            q_valid,
	input  wire logic       q_ready,
	output qitem_t          q_item
);

	qitem_t     slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       pop;
	cls_t       cls;

	// Classify the incoming byte.
	always_comb begin
		case (data_byte)
			CH_CR:    cls = CLS_CR;
			CH_LF:    cls = CLS_LF;
			CH_SPACE: cls = CLS_SPACE;
			CH_SLASH: cls = CLS_SLASH;
			CH_G:     cls = CLS_G;
			CH_E:     cls = CLS_E;
			CH_T:     cls = CLS_T;
			CH_H:     cls = CLS_H;
			CH_P:     cls = CLS_P;
			CH_DOT:   cls = CLS_DOT;
			CH_ZERO:  cls = CLS_ZERO;
			CH_ONE:   cls = CLS_ONE;
			default:  cls = CLS_OTHER;
		endcase
	end

	assign in_ready = (count_q != 2'd2);
	assign push     = in_valid && in_ready;
	assign q_valid  = (count_q != 2'd0);
	assign pop      = q_valid && q_ready;
	assign q_item   = slot_q[rd_ptr_q];

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= '{start: starts_request, cls: cls};
		end
	end

	// Queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	// The fill count never goes past the queue depth.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3)
		else $error("front queue count out of range");

	// The pointers differ exactly when the queue holds one entry.
	a_ptr_count: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_ptr_q != rd_ptr_q) == (count_q == 2'd1))
		else $error("front queue pointers disagree with count");

	// A pop with no push leaves one entry fewer.
	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !push) |=> (count_q == $past(count_q) - 2'd1))
		else $error("front queue lost track of a pop");

endmodule

`default_nettype wire

// ----- rtl/hrlc_back.sv -----
// ----------------------------------------------------------------------------
// hrlc_back: request-line state and verdict stage
// Takes classified bytes from the queue, tracks the first line and the blank
// line terminator, and loads at most one verdict per request into the output
// register.
// ----------------------------------------------------------------------------
`default_nettype none

module hrlc_back import hrlc_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [15:0] cfg_wdata,
	input  wire logic        q_valid,
	output logic             q_ready,
	input  wire qitem_t      q_item,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       verdict
);

	// Progress through the first line.
	typedef struct packed {
		logic [1:0] spaces;
		logic [2:0] mprog;
		logic       mmis;
		logic [1:0] tgt;
		logic [3:0] vprog;
		logic       vmis;
	} line_t;

	logic [15:0] limit_q;
	logic [15:0] bytes_q;
	logic [1:0]  term_q;
	logic        given_q;
	logic        ended_q;
	logic        crp_q;
	line_t       line_q;
	logic        out_valid_q;
	logic [1:0]  verdict_q;

	logic [15:0] bytes_d;
	logic [1:0]  term_d;
	logic        given_d;
	logic        ended_d;
	logic        crp_d;
	line_t       line_d;
	logic        pop;
	logic        emit;
	logic        done;
	logic [1:0]  result;

	// Expected class for each position of the method text.
	function automatic cls_t method_cls(input logic [1:0] idx);
		cls_t c;
		case (idx)
			2'd0:    c = CLS_G;
			2'd1:    c = CLS_E;
			2'd2:    c = CLS_T;
			default: c = CLS_OTHER;
		endcase
		return c;
	endfunction

	// Expected class for each position of the version prefix.
	function automatic cls_t version_cls(input logic [2:0] idx);
		cls_t c;
		case (idx)
			3'd0:    c = CLS_H;
			3'd1:    c = CLS_T;
			3'd2:    c = CLS_T;
			3'd3:    c = CLS_P;
			3'd4:    c = CLS_SLASH;
			3'd5:    c = CLS_ONE;
			3'd6:    c = CLS_DOT;
			default: c = CLS_OTHER;
		endcase
		return c;
	endfunction

	// Advance the first-line checks by one line byte.
	function automatic line_t feed(input line_t s, input cls_t c);
		line_t n;
		n = s;
		if (c == CLS_SPACE) begin
			if (s.spaces != 2'd3) begin
				n.spaces = s.spaces + 2'd1;
			end
		end else if (s.spaces == 2'd0) begin
			if (!s.mmis) begin
				if (s.mprog < 3'd3 && c == method_cls(s.mprog[1:0])) begin
					n.mprog = s.mprog + 3'd1;
				end else begin
					n.mmis = 1'b1;
				end
			end
		end else if (s.spaces == 2'd1) begin
			if (s.tgt == 2'd0) begin
				n.tgt = (c == CLS_SLASH) ? 2'd1 : 2'd2;
			end
		end else if (s.spaces == 2'd2) begin
			if (!s.vmis) begin
				if (s.vprog < 4'd7 && c == version_cls(s.vprog[2:0])) begin
					n.vprog = s.vprog + 4'd1;
				end else if (s.vprog == 4'd7 && (c == CLS_ZERO || c == CLS_ONE)) begin
					n.vprog = 4'd8;
				end else begin
					n.vmis = 1'b1;
				end
			end
		end
		return n;
	endfunction

	assign q_ready = !out_valid_q || out_ready;
	assign pop     = q_valid && q_ready;

	// Next-state logic for one request byte.
	always_comb begin
		// A start flag clears the request state before the byte is used.
		if (q_item.start) begin
			bytes_d = '0;
			term_d  = '0;
			given_d = 1'b0;
			ended_d = 1'b0;
			crp_d   = 1'b0;
			line_d  = '0;
		end else begin
			bytes_d = bytes_q;
			term_d  = term_q;
			given_d = given_q;
			ended_d = ended_q;
			crp_d   = crp_q;
			line_d  = line_q;
		end
		emit   = 1'b0;
		done   = 1'b0;
		result = VERDICT_OK;

		if (!given_d) begin
			// First line: a CR only ends the line when an LF follows it.
			if (!ended_d) begin
				if (crp_d) begin
					crp_d = 1'b0;
					if (q_item.cls == CLS_LF) begin
						ended_d = 1'b1;
					end else begin
						line_d = feed(line_d, CLS_CR);
					end
				end
				if (!ended_d) begin
					if (q_item.cls == CLS_CR) begin
						crp_d = 1'b1;
					end else begin
						line_d = feed(line_d, q_item.cls);
					end
				end
			end

			// Blank-line terminator.
			case (q_item.cls)
				CLS_CR: begin
					term_d = (term_d == 2'd2) ? 2'd3 : 2'd1;
				end
				CLS_LF: begin
					if (term_d == 2'd3) begin
						done   = 1'b1;
						term_d = 2'd0;
					end else begin
						term_d = (term_d == 2'd1) ? 2'd2 : 2'd0;
					end
				end
				default: begin
					term_d = 2'd0;
				end
			endcase

			// Saturating byte count.
			if (bytes_d != 16'hFFFF) begin
				bytes_d = bytes_d + 16'd1;
			end

			// Verdict: terminator first, then the byte limit.
			if (done) begin
				emit = 1'b1;
				if (!ended_d || line_d.spaces != 2'd2 || line_d.tgt != 2'd1 ||
				    line_d.vmis || line_d.vprog != 4'd8) begin
					result = VERDICT_BAD_REQUEST;
				end else if (line_d.mmis || line_d.mprog != 3'd3) begin
					result = VERDICT_METHOD_NOT_ALLOWED;
				end else begin
					result = VERDICT_OK;
				end
			end else if (bytes_d >= limit_q) begin
				emit   = 1'b1;
				result = VERDICT_TOO_LARGE;
			end
			if (emit) begin
				given_d = 1'b1;
			end
		end
	end

	// Limit register and request state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
			bytes_q <= '0;
			term_q  <= '0;
			given_q <= 1'b0;
			ended_q <= 1'b0;
			crp_q   <= 1'b0;
			line_q  <= '0;
		end else begin
			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end
			if (pop) begin
				bytes_q <= bytes_d;
				term_q  <= term_d;
				given_q <= given_d;
				ended_q <= ended_d;
				crp_q   <= crp_d;
				line_q  <= line_d;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop && emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && emit) begin
			verdict_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign verdict   = verdict_q;

	// A verdict marks the request as answered.
	a_emit_given: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && emit) |=> (given_q && out_valid_q))
		else $error("verdict given without marking the request");

	// An answered request stays silent until a new one starts.
	a_silent_after: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && given_q && !q_item.start) |-> !emit)
		else $error("second verdict for one request");

	// Any verdict other than too-large needs a finished first line.
	a_line_first: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && emit && result != VERDICT_TOO_LARGE) |-> ended_d)
		else $error("line verdict before the first line ended");

endmodule

`default_nettype wire

// ----- tb/tb_http_request_line_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_http_request_line_checker: self-checking bench for the request-line checker
// Streams request bytes through the valid/ready input and compares every
// verdict with a cycle-free predictor of the checker, over several limits.
// ----------------------------------------------------------------------------

module tb_http_request_line_checker;
	import hrlc_pkg::*;

	// Target classification codes used by the predictor.
	localparam logic [1:0] TARGET_EMPTY = 2'd0;
	localparam logic [1:0] TARGET_SLASH = 2'd1;
	localparam logic [1:0] TARGET_OTHER = 2'd2;

	localparam int NUM_PHASES  = 9;
	localparam int HOLD_PHASE  = 6;
	localparam int HOLD_CYCLES = 300;
	localparam int TAIL_CYCLES = 8;

	// One request byte as it goes out on the input channel.
	typedef struct packed {
		logic       start;
		logic [7:0] b;
	} req_byte_t;

	// Predicted parser state of the checker.
	typedef struct packed {
		logic [15:0] count;
		logic [1:0]  term_step;
		logic        answered;
		logic        line_done;
		logic        cr_held;
		logic [1:0]  spaces;
		logic [2:0]  meth_pos;
		logic        meth_bad;
		logic [1:0]  target;
		logic [3:0]  ver_pos;
		logic        ver_bad;
	} parse_state_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [15:0] cfg_wdata = 16'd0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  data_byte = 8'd0;
	logic        starts_request = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  verdict;

	logic        hold_off = 1'b0;
	int          phase_no = -1;
	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;

	req_byte_t    bytes_to_send[$];
	logic [1:0]   verdicts_due[$];
	logic [7:0]   req_bytes[$];
	parse_state_t ps;
	logic [15:0]  header_limit;
	int unsigned  n_queued = 0;
	int unsigned  n_accepted = 0;
	int unsigned  n_errors = 0;
	req_byte_t    next_byte;
	logic [1:0]   want_verdict;
	logic [1:0]   due_verdict;

	http_request_line_checker dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.data_byte      (data_byte),
		.starts_request (starts_request),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.verdict        (verdict)
	);

	// Clock with a 2 ns period.
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	function automatic logic [7:0] method_char(input logic [2:0] pos);
		case (pos)
			3'd0:    return CH_G;
			3'd1:    return CH_E;
			default: return CH_T;
		endcase
	endfunction

	function automatic logic [7:0] version_char(input logic [3:0] pos);
		case (pos)
			4'd0:    return CH_H;
			4'd1:    return CH_T;
			4'd2:    return CH_T;
			4'd3:    return CH_P;
			4'd4:    return CH_SLASH;
			4'd5:    return CH_ONE;
			default: return CH_DOT;
		endcase
	endfunction

	// Feeds one character of the first line into the field matchers.
	function automatic void feed_line_char(input logic [7:0] c);
		if (c == CH_SPACE) begin
			if (ps.spaces != 2'd3)
				ps.spaces = ps.spaces + 2'd1;
			return;
		end
		case (ps.spaces)
			2'd0: begin
				if (!ps.meth_bad) begin
					if (ps.meth_pos < 3'd3 && c == method_char(ps.meth_pos))
						ps.meth_pos = ps.meth_pos + 3'd1;
					else
						ps.meth_bad = 1'b1;
				end
			end
			2'd1: begin
				if (ps.target == TARGET_EMPTY)
					ps.target = (c == CH_SLASH) ? TARGET_SLASH : TARGET_OTHER;
			end
			2'd2: begin
				if (!ps.ver_bad) begin
					if (ps.ver_pos < 4'd7 && c == version_char(ps.ver_pos))
						ps.ver_pos = ps.ver_pos + 4'd1;
					else if (ps.ver_pos == 4'd7 && (c == CH_ZERO || c == CH_ONE))
						ps.ver_pos = 4'd8;
					else
						ps.ver_bad = 1'b1;
				end
			end
			default: ;
		endcase
	endfunction

	// A CR only ends the line when an LF follows; otherwise it is a line byte.
	function automatic void track_line(input logic [7:0] c);
		if (ps.line_done)
			return;
		if (ps.cr_held) begin
			ps.cr_held = 1'b0;
			if (c == CH_LF) begin
				ps.line_done = 1'b1;
				return;
			end
			feed_line_char(CH_CR);
		end
		if (c == CH_CR)
			ps.cr_held = 1'b1;
		else
			feed_line_char(c);
	endfunction

	// Returns 1 when this byte completes the blank-line terminator.
	function automatic logic terminator_done(input logic [7:0] c);
		if (c == CH_CR) begin
			ps.term_step = (ps.term_step == 2'd2) ? 2'd3 : 2'd1;
		end else if (c == CH_LF) begin
			if (ps.term_step == 2'd3) begin
				ps.term_step = 2'd0;
				return 1'b1;
			end
			ps.term_step = (ps.term_step == 2'd1) ? 2'd2 : 2'd0;
		end else begin
			ps.term_step = 2'd0;
		end
		return 1'b0;
	endfunction

	function automatic logic [1:0] line_verdict();
		if (!ps.line_done || ps.spaces != 2'd2 || ps.target != TARGET_SLASH ||
				ps.ver_bad || ps.ver_pos != 4'd8)
			return VERDICT_BAD_REQUEST;
		if (ps.meth_bad || ps.meth_pos != 3'd3)
			return VERDICT_METHOD_NOT_ALLOWED;
		return VERDICT_OK;
	endfunction

	// Advances the predicted state by one accepted byte; returns 1 with a verdict.
	function automatic logic predict_verdict(input logic [7:0] c, input logic start,
			output logic [1:0] v);
		logic hit;
		v = VERDICT_OK;
		if (start)
			ps = '0;
		if (ps.answered)
			return 1'b0;
		track_line(c);
		hit = terminator_done(c);
		if (ps.count != 16'hFFFF)
			ps.count = ps.count + 16'd1;
		if (hit) begin
			ps.answered = 1'b1;
			v = line_verdict();
			return 1'b1;
		end
		if (ps.count >= header_limit) begin
			ps.answered = 1'b1;
			v = VERDICT_TOO_LARGE;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// ------------------------------------------------------------------
	// Request builders
	// ------------------------------------------------------------------

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			req_bytes.push_back(s[i]);
	endtask

	task automatic add_crlf();
		req_bytes.push_back(CH_CR);
		req_bytes.push_back(CH_LF);
	endtask

	// Occasionally drops a lone CR or a bare LF into the line.
	task automatic maybe_stray();
		if ($urandom_range(99) < 6)
			req_bytes.push_back($urandom_range(1) ? CH_CR : CH_LF);
	endtask

	// Moves the built request into the send queue, flagging its first byte.
	task automatic commit_request();
		req_byte_t rb;
		for (int i = 0; i < req_bytes.size(); i++) begin
			rb.start = (i == 0);
			rb.b = req_bytes[i];
			bytes_to_send.push_back(rb);
		end
		n_queued += req_bytes.size();
		req_bytes.delete();
	endtask

	function automatic logic [7:0] noise_byte();
		case ($urandom_range(9))
			0, 1:    return CH_CR;
			2:       return CH_LF;
			3:       return CH_SPACE;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	// Mostly well-formed requests with random content, some noise and damage.
	task automatic build_request();
		int unsigned n;
		int unsigned cut;
		string s;
		string path_set;
		path_set = "abz09/._-?=%~";
		req_bytes.delete();
		if ($urandom_range(99) < 12) begin
			n = $urandom_range(24, 1);
			repeat (n) req_bytes.push_back(noise_byte());
		end else begin
			case ($urandom_range(9))
				0, 1, 2, 3, 4, 5: s = "GET";
				6:                s = "POST";
				7:                s = "";
				8:                s = "GE";
				default:          s = "GETS";
			endcase
			add_text(s);
			maybe_stray();
			n = ($urandom_range(9) == 0) ? $urandom_range(2) : 1;
			repeat (n) req_bytes.push_back(CH_SPACE);
			case ($urandom_range(7))
				0: ;
				1: add_text("index");
				default: begin
					req_bytes.push_back(CH_SLASH);
					repeat ($urandom_range(6))
						req_bytes.push_back(path_set[$urandom_range(path_set.len() - 1)]);
				end
			endcase
			maybe_stray();
			n = ($urandom_range(9) == 0) ? $urandom_range(2) : 1;
			repeat (n) req_bytes.push_back(CH_SPACE);
			case ($urandom_range(9))
				0, 1, 2, 3: s = "HTTP/1.1";
				4, 5:       s = "HTTP/1.0";
				6:          s = "HTTP/1.2";
				7:          s = "HTTP/1.";
				8:          s = "HTTP/1.10";
				default:    s = "http/1.1";
			endcase
			add_text(s);
			maybe_stray();
			add_crlf();
			repeat ($urandom_range(2)) begin
				add_text("Host: x");
				if ($urandom_range(7) == 0)
					req_bytes.push_back(CH_CR);
				add_crlf();
			end
			add_crlf();
			// Damage a byte or cut the request short now and then.
			if ($urandom_range(99) < 10)
				req_bytes[$urandom_range(req_bytes.size() - 1)] = 8'($urandom_range(255));
			if ($urandom_range(99) < 10) begin
				cut = $urandom_range(req_bytes.size() - 1, 1);
				repeat (cut) void'(req_bytes.pop_back());
			end
			// Trailing bytes after the terminator must be ignored.
			if ($urandom_range(99) < 15)
				repeat ($urandom_range(3, 1)) req_bytes.push_back(8'($urandom_range(255)));
		end
		commit_request();
	endtask

	// ------------------------------------------------------------------
	// Driver, receiver and monitor
	// ------------------------------------------------------------------

	// Offer the next request byte once the current one is taken.
	always @(posedge clk) begin
		if (!in_valid || in_ready) begin
			if (bytes_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				next_byte = bytes_to_send.pop_front();
				in_valid <= 1'b1;
				data_byte <= next_byte.b;
				starts_request <= next_byte.start;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver readiness, with random stalls and the long hold-off.
	always @(posedge clk)
		out_ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);

	// Predict on every accepted request byte, check every accepted verdict.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				n_accepted++;
				if (predict_verdict(data_byte, starts_request, want_verdict))
					verdicts_due.push_back(want_verdict);
			end
			if (out_valid && out_ready) begin
				if (verdicts_due.size() == 0) begin
					if (n_errors < 10)
						$display("verdict %0d given with none expected", verdict);
					n_errors++;
				end else begin
					due_verdict = verdicts_due.pop_front();
					if (verdict !== due_verdict) begin
						if (n_errors < 10)
							$display("verdict mismatch: expected %0d, got %0d",
								due_verdict, verdict);
						n_errors++;
					end
				end
			end
		end
	end

	// Long receiver hold-off so that the checker fills up and stalls its input.
	initial begin
		wait (phase_no == HOLD_PHASE);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off <= 1'b0;
	end

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------

	task automatic write_limit(input logic [15:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		header_limit = value;
	endtask

	// Wait until every byte is taken and every verdict is in, then let the
	// pipeline settle for bytes that give no verdict.
	task automatic drain();
		while (n_accepted != n_queued || verdicts_due.size() != 0)
			@(negedge clk);
		repeat (6) @(posedge clk);
	endtask

	initial begin
		logic [15:0] limit_value;
		int unsigned budget;
		int unsigned goal;
		ps = '0;
		header_limit = LIMIT_RESET;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int p = 0; p < NUM_PHASES; p++) begin
			case (p)
				0:       begin limit_value = LIMIT_RESET; budget = 150; end
				1:       begin limit_value = 16'd4;       budget = 150; end
				2:       begin limit_value = 16'd18;      budget = 180; end
				3:       begin limit_value = 16'd0;       budget = 40;  end
				4:       begin limit_value = 16'd3;       budget = 40;  end
				5:       begin limit_value = 16'hFFFF;    budget = 200; end
				6:       begin limit_value = 16'd40;      budget = 220; end
				7:       begin limit_value = 16'd1000;    budget = 200; end
				default: begin limit_value = LIMIT_RESET; budget = 150; end
			endcase
			if (p < 3) begin
				send_idle_pct = 20;
				recv_idle_pct = 53;
			end else if (p < 6) begin
				send_idle_pct = 53;
				recv_idle_pct = 20;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			phase_no = p;
			if (p != 0)
				write_limit(limit_value);

			// Fixed requests count toward the phase budget.
			goal = n_queued + budget;

			if (p == 0) begin
				// A clean GET, two ignored bytes after its verdict, then an
				// empty first line.
				add_text("GET / HTTP/1.1");
				add_crlf();
				add_crlf();
				req_bytes.push_back(8'hFF);
				req_bytes.push_back(8'h00);
				commit_request();
				add_crlf();
				add_crlf();
				commit_request();
			end
			if (p == 7) begin
				// One request that runs past the limit without a terminator.
				add_text("GET /");
				repeat (1100) req_bytes.push_back(8'($urandom_range(255, 33)));
				commit_request();
			end

			while (n_queued < goal)
				build_request();
			drain();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (n_errors == 0 && verdicts_due.size() == 0)
			$display("tb_http_request_line_checker: clean");
		else
			$display("tb_http_request_line_checker: errors");
		$finish;
	end

	// Run limit.
	initial begin
		#400000;
		$display("tb_http_request_line_checker: errors");
		$finish;
	end

endmodule

// ----- http_request_line_checker.f -----
rtl/hrlc_pkg.sv
rtl/hrlc_front.sv
rtl/hrlc_back.sv
rtl/http_request_line_checker.sv
tb/tb_http_request_line_checker.sv
